// ===== rtl/dramp_pkg.sv =====
`default_nettype none

package dramp_pkg;

   // Frame geometry
   localparam int FRAME_LEN = 12;
   localparam int CNT_W     = $clog2(FRAME_LEN + 1);

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAMP_STEP    = 1'b0,
      CSR_OUTPUT_SCALE = 1'b1
   } csr_idx_type;

   // Input item kinds
   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_TICK = 1'b1
   } act_type;

   // Register reset values
   localparam logic [14:0] RAMP_STEP_RST    = 15'd128;
   localparam logic [15:0] OUTPUT_SCALE_RST = 16'd26214;

   // Float exponent bias minus the eight fraction bits of Q8.8
   localparam logic [7:0] EXP_OFFSET = 8'd119;

   // Frame characters
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_C    = 8'h43;
   localparam logic [7:0] CH_O    = 8'h4F;
   localparam logic [7:0] CH_L    = 8'h4C;
   localparam logic [7:0] CH_R    = 8'h52;
   localparam logic [7:0] CH_STAR = 8'h2A;

   // Sum of the fixed header bytes, mod 256
   localparam logic [7:0] HDR_SUM = 8'(CH_HASH + CH_P + CH_C + CH_O + CH_L);

   // Encoded duty handed to the frame serializer
   typedef struct packed {
      logic        neg;
      logic [31:0] bits;
   } flt_type;

endpackage

`default_nettype wire

// ===== rtl/dramp_if.sv =====
`default_nettype none

// Command channel: setpoint loads and ticks
interface dramp_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [15:0] setpoint;

   modport source (output valid, action, setpoint, input ready);
   modport sink   (input valid, action, setpoint, output ready);
endinterface

// Frame byte channel
interface dramp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last;

   modport source (output valid, frame_byte, last, input ready);
   modport sink   (input valid, frame_byte, last, output ready);
endinterface

// Register write channel
interface dramp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dramp_pkg::CSR_IDX_W-1:0]  index;
   logic [15:0]                      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/duty_ramp_motor_frame_builder.sv =====
`default_nettype none

// Channel   Dir  Payload                       Transfer
// req_ch    in   action, setpoint (Q8.8)       valid && ready
// rsp_ch    out  frame_byte, last              valid && ready
// csr_ch    in   index, data                   valid && ready (always ready)
//
// A tick gives 12 frame bytes, one per cycle while rsp_ch is ready; the frame serializer
// takes the next frame as the last byte of the current one is sent.
// First byte of a frame passes the ramp, multiply, float encode and frame load
// registers after its tick is taken. Up to three more ticks queue in those registers.
// Synchronous reset clears duty state and all stage valids, and sets the registers to their reset values.
// A stalled rsp_ch holds its byte; stalls back up stage by stage to req_ch.

module duty_ramp_motor_frame_builder #(
   parameter int DUTY_WIDTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dramp_req_if.sink  req_ch,
   dramp_rsp_if.source rsp_ch,
   dramp_csr_if.sink  csr_ch
);
   import dramp_pkg::*;

   logic [14:0]                  ramp_step_ff;
   logic [15:0]                  output_scale_ff;
   logic                         duty_valid;
   logic                         duty_ready;
   logic signed [DUTY_WIDTH-1:0] duty;
   logic                         flt_valid;
   logic                         flt_ready;
   flt_type                      flt;

   // Configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_step_ff    <= RAMP_STEP_RST;
         output_scale_ff <= OUTPUT_SCALE_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_RAMP_STEP:    ramp_step_ff    <= csr_ch.data[14:0];
            CSR_OUTPUT_SCALE: output_scale_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Ramp toward target
   dramp_ramp #(.DUTY_WIDTH(DUTY_WIDTH)) u_ramp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .action    (req_ch.action),
      .setpoint  (req_ch.setpoint),
      .ramp_step (ramp_step_ff),
      .out_valid (duty_valid),
      .out_ready (duty_ready),
      .out_duty  (duty)
   );

   // Scale and float encode
   dramp_scale #(.DUTY_WIDTH(DUTY_WIDTH)) u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (duty_valid),
      .in_ready     (duty_ready),
      .in_duty      (duty),
      .output_scale (output_scale_ff),
      .out_valid    (flt_valid),
      .out_ready    (flt_ready),
      .out_flt      (flt)
   );

   // Frame build and byte serializer
   dramp_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (flt_valid),
      .in_ready  (flt_ready),
      .in_flt    (flt),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_byte  (rsp_ch.frame_byte),
      .out_last  (rsp_ch.last)
   );

endmodule

`default_nettype wire

// ===== rtl/dramp_ramp.sv =====
`default_nettype none

module dramp_ramp #(
   parameter int DUTY_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic                         action,
   input  wire logic signed [15:0]           setpoint,
   input  wire logic [14:0]                  ramp_step,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [DUTY_WIDTH-1:0]      out_duty
);
   import dramp_pkg::*;

   localparam int DW = DUTY_WIDTH;
   localparam int EW = (DW > 16) ? DW : 16;
   localparam int RW = EW + 2;
   localparam logic signed [EW-1:0] DMAX = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [EW-1:0] DMIN = ~DMAX;

   logic signed [DW-1:0] cur_ff, cur_in;
   logic signed [DW-1:0] tgt_ff, tgt_in;
   logic                 s1_valid_ff;
   logic signed [EW-1:0] sp_ext;
   logic signed [RW-1:0] cur_w, tgt_w, step_w, up_w, down_w;
   logic                 accept;

   assign accept    = in_valid && in_ready;
   assign in_ready  = !s1_valid_ff || out_ready;
   assign out_valid = s1_valid_ff;
   assign out_duty  = cur_ff;

   // Setpoint into duty range
   always_comb begin
      sp_ext = EW'(setpoint);
      if (sp_ext > DMAX) begin
         tgt_in = DW'(DMAX);
      end else if (sp_ext < DMIN) begin
         tgt_in = DW'(DMIN);
      end else begin
         tgt_in = DW'(sp_ext);
      end
   end

   // One ramp step toward the target, clamped at it
   always_comb begin
      cur_w  = RW'(cur_ff);
      tgt_w  = RW'(tgt_ff);
      step_w = $signed({{(RW-15){1'b0}}, ramp_step});
      up_w   = cur_w + step_w;
      down_w = cur_w - step_w;
      if (cur_w < tgt_w) begin
         cur_in = (up_w >= tgt_w) ? tgt_ff : DW'(up_w);
      end else if (cur_w > tgt_w) begin
         cur_in = (down_w <= tgt_w) ? tgt_ff : DW'(down_w);
      end else begin
         cur_in = cur_ff;
      end
   end

   // Duty state; cur_ff doubles as the stage payload
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         tgt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept && action == ACT_TICK) begin
            cur_ff      <= cur_in;
            s1_valid_ff <= 1'b1;
         end else if (out_ready) begin
            s1_valid_ff <= 1'b0;
         end
         if (accept && action == ACT_LOAD) begin
            tgt_ff <= tgt_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dramp_scale.sv =====
`default_nettype none

module dramp_scale #(
   parameter int DUTY_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [DUTY_WIDTH-1:0] in_duty,
   input  wire logic [15:0]                  output_scale,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output dramp_pkg::flt_type                out_flt
);
   import dramp_pkg::*;

   localparam int DW = DUTY_WIDTH;
   localparam int SW = DW - 1;
   localparam int PW = $clog2(SW);

   logic [DW-1:0]    mag;
   logic [DW+15:0]   prod;
   logic [SW-1:0]    scaled_ff;
   logic             neg2_ff;
   logic             s2_valid_ff;
   logic             s2_ready;
   logic [PW-1:0]    msb_pos;
   logic [23:0]      shifted;
   flt_type          flt_in, flt_ff;
   logic             s3_valid_ff;
   logic             s3_ready;

   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign in_ready  = s2_ready;
   assign out_valid = s3_valid_ff;
   assign out_flt   = flt_ff;

   // Magnitude times Q0.16 factor
   always_comb begin
      mag  = in_duty[DW-1] ? DW'(~in_duty + DW'(1)) : DW'(in_duty);
      prod = (DW+16)'(mag) * (DW+16)'(output_scale);
   end

   // Leading one, exponent and mantissa
   always_comb begin
      msb_pos = '0;
      for (int i = 0; i < SW; i++) begin
         if (scaled_ff[i]) begin
            msb_pos = PW'(i);
         end
      end
      shifted     = 24'(scaled_ff) << (5'd23 - 5'(msb_pos));
      flt_in.neg  = neg2_ff;
      if (scaled_ff == '0) begin
         flt_in.bits = '0;
      end else begin
         flt_in.bits = {1'b0, 8'(EXP_OFFSET + 8'(msb_pos)), shifted[22:0]};
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (in_valid && s2_ready) begin
         scaled_ff <= prod[DW+14:16];
         neg2_ff   <= in_duty[DW-1];
      end
      if (s2_valid_ff && s3_ready) begin
         flt_ff <= flt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dramp_frame.sv =====
`default_nettype none

module dramp_frame (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire dramp_pkg::flt_type in_flt,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [7:0]              out_byte,
   output logic                    out_last
);
   import dramp_pkg::*;

   logic [7:0]       frame_ff [FRAME_LEN];
   logic [CNT_W-1:0] cnt_ff;
   logic [7:0]       dir;
   logic [7:0]       csum;
   logic             xfer;
   logic             load;

   assign out_valid = cnt_ff != '0;
   assign out_last  = cnt_ff == CNT_W'(1);
   assign out_byte  = frame_ff[0];
   assign xfer      = out_valid && out_ready;
   assign in_ready  = !out_valid || (xfer && out_last);
   assign load      = in_valid && in_ready;

   // Direction byte and checksum over bytes 0..9
   always_comb begin
      dir  = in_flt.neg ? CH_L : CH_R;
      csum = 8'(8'd0 - 8'(HDR_SUM + dir + in_flt.bits[31:24] + in_flt.bits[23:16]
                          + in_flt.bits[15:8] + in_flt.bits[7:0]));
   end

   // Bytes left in the current frame
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= CNT_W'(FRAME_LEN);
      end else if (xfer) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   // Frame shift register, head byte drives the output
   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff[0]  <= CH_HASH;
         frame_ff[1]  <= CH_P;
         frame_ff[2]  <= CH_C;
         frame_ff[3]  <= CH_O;
         frame_ff[4]  <= CH_L;
         frame_ff[5]  <= dir;
         frame_ff[6]  <= in_flt.bits[31:24];
         frame_ff[7]  <= in_flt.bits[23:16];
         frame_ff[8]  <= in_flt.bits[15:8];
         frame_ff[9]  <= in_flt.bits[7:0];
         frame_ff[10] <= csum;
         frame_ff[11] <= CH_STAR;
      end else if (xfer) begin
         for (int i = 0; i < FRAME_LEN - 1; i++) begin
            frame_ff[i] <= frame_ff[i+1];
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dramp_check.sv =====
`default_nettype none

module dramp_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic       rsp_last
);
   import dramp_pkg::*;

   // Pending byte stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   // Closing byte of every frame
   a_last_star: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_frame_byte == CH_STAR)
      else $error("last byte is not the closing asterisk");

   // A new frame starts with its header
   a_next_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || rsp_frame_byte == CH_HASH)
      else $error("frame after last byte does not open with header");

   // Reset empties the output
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind duty_ramp_motor_frame_builder dramp_check u_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_frame_byte (rsp_ch.frame_byte),
   .rsp_last       (rsp_ch.last)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dramp_pkg::*;

   localparam int CLK_HALF    = 4;
   localparam int RESET_CYC   = 7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_CAP  = 100;
   localparam int BEATS       = 12;

   // Frame characters
   localparam logic [7:0] HASH_CH = "#";
   localparam logic [7:0] P_CH    = "P";
   localparam logic [7:0] C_CH    = "C";
   localparam logic [7:0] O_CH    = "O";
   localparam logic [7:0] L_CH    = "L";
   localparam logic [7:0] R_CH    = "R";
   localparam logic [7:0] STAR_CH = "*";

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
   } frame_beat_type;

   logic clock;
   logic reset;

   dramp_req_if req_bus ();
   dramp_rsp_if rsp_bus ();
   dramp_csr_if csr_bus ();

   duty_ramp_motor_frame_builder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Predicted block state and registers
   int          duty_now;
   int          duty_goal;
   logic [14:0] step_q88;
   logic [15:0] scale_q016;

   frame_beat_type frame_due [$];
   int             fault_count;
   int             cycle_count;
   bit             calm_tail;

   // Clock
   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d frame bytes pending", $time,
                  frame_due.size());
         $display("duty_ramp_motor_frame_builder: mismatch");
         $finish;
      end
   end

   // Sink side backpressure: random stall bursts, none in the tail
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Q8.8 magnitude to IEEE-754 single, exact for 16 bits
   function automatic logic [31:0] q88_to_single(logic [15:0] scaled);
      int          msb;
      logic [31:0] norm;
      logic [7:0]  expo;
      if (scaled == 16'd0)
         return 32'd0;
      msb = 15;
      while (!scaled[msb])
         msb--;
      norm = 32'(scaled) << (23 - msb);
      expo = 8'(127 + msb - 8);
      return {1'b0, expo, norm[22:0]};
   endfunction

   // One tick: slew the duty toward the goal, then queue the frame it sends
   task automatic ramp_and_build_frame();
      int             step_i;
      int             scale_i;
      int             mag;
      int             prod;
      int             i;
      logic [15:0]    scaled;
      logic [31:0]    fbits;
      logic [7:0]     fr [BEATS];
      logic [7:0]     sum;
      frame_beat_type beat;
      step_i  = step_q88;
      scale_i = scale_q016;
      if (duty_now < duty_goal) begin
         duty_now += step_i;
         if (duty_now >= duty_goal)
            duty_now = duty_goal;
      end else if (duty_now > duty_goal) begin
         duty_now -= step_i;
         if (duty_now <= duty_goal)
            duty_now = duty_goal;
      end
      mag    = (duty_now < 0) ? -duty_now : duty_now;
      prod   = mag * scale_i;
      scaled = 16'(prod >>> 16);
      fbits  = q88_to_single(scaled);
      fr[0]  = HASH_CH;
      fr[1]  = P_CH;
      fr[2]  = C_CH;
      fr[3]  = O_CH;
      fr[4]  = L_CH;
      fr[5]  = (duty_now >= 0) ? R_CH : L_CH;
      fr[6]  = fbits[31:24];
      fr[7]  = fbits[23:16];
      fr[8]  = fbits[15:8];
      fr[9]  = fbits[7:0];
      sum    = 8'd0;
      for (i = 0; i < 10; i++)
         sum += fr[i];
      fr[10] = 8'd0 - sum;
      fr[11] = STAR_CH;
      for (i = 0; i < BEATS; i++) begin
         beat.frame_byte = fr[i];
         beat.last       = (i == BEATS - 1);
         frame_due.push_back(beat);
      end
   endtask

   // Send one command; predict at the transfer, then maybe idle
   task automatic issue_command(act_type act, logic signed [15:0] sp);
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.setpoint <= sp;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (act == ACT_LOAD)
         duty_goal = sp;
      else
         ramp_and_build_frame();
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic issue_ticks(int count);
      repeat (count) issue_command(ACT_TICK, 16'($urandom));
   endtask

   // Stop sending and let every queued frame drain
   task automatic settle_outputs();
      req_bus.valid <= 1'b0;
      while (frame_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write both registers; the block is idle here
   task automatic program_regs(logic [15:0] step_word, logic [15:0] scale_word);
      int k;
      for (k = 0; k < 2; k++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= (k == 0) ? CSR_RAMP_STEP : CSR_OUTPUT_SCALE;
         csr_bus.data  <= (k == 0) ? step_word : scale_word;
         @(posedge clock);
         while (!csr_bus.ready)
            @(posedge clock);
         if (k == 0)
            step_q88 = step_word[14:0];
         else
            scale_q016 = scale_word;
      end
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_setpoint();
      case ($urandom_range(0, 6))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // Result checker
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frame_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
               $display("%0t: unexpected frame byte: expected none, actual %h last %b",
                        $time, rsp_bus.frame_byte, rsp_bus.last);
         end else begin
            want = frame_due.pop_front();
            if (rsp_bus.frame_byte !== want.frame_byte) begin
               fault_count++;
               if (fault_count <= REPORT_CAP)
                  $display("%0t: frame_byte expected %h actual %h", $time,
                           want.frame_byte, rsp_bus.frame_byte);
            end
            if (rsp_bus.last !== want.last) begin
               fault_count++;
               if (fault_count <= REPORT_CAP)
                  $display("%0t: last expected %b actual %b", $time,
                           want.last, rsp_bus.last);
            end
         end
      end
   end

   // Reset register values, including a zero-duty frame and a clamp at target
   task automatic check_power_on_defaults();
      issue_command(ACT_TICK, 16'sh0000);
      issue_command(ACT_LOAD, 16'sh0180);
      issue_ticks(4);
      settle_outputs();
   endtask

   // Largest step and scale, both duty limits, most negative duty, zero scale
   task automatic check_range_extremes();
      program_regs(16'hFFFF, 16'hFFFF);
      issue_command(ACT_LOAD, 16'sh7FFF);
      issue_ticks(2);
      issue_command(ACT_LOAD, 16'sh8000);
      issue_ticks(3);
      settle_outputs();
      program_regs(16'h7FFF, 16'h0000);
      issue_ticks(1);
      settle_outputs();
   endtask

   // Zero step holds the duty; unit step with half scale
   task automatic check_stalled_step();
      program_regs(16'h8000, 16'h8000);
      issue_command(ACT_LOAD, 16'sh0064);
      issue_ticks(1);
      settle_outputs();
      program_regs(16'h0001, 16'h8000);
      issue_ticks(1);
      settle_outputs();
   endtask

   // Ramps toward random targets under several register settings
   task automatic check_random_ramps(int budget);
      int          sent;
      int          phase;
      int          in_phase;
      int          ticks;
      logic [15:0] step_word;
      logic [15:0] scale_word;
      sent  = 0;
      phase = 0;
      while (sent < budget) begin
         settle_outputs();
         case (phase)
            0: begin
               step_word  = 16'hFFFF;
               scale_word = 16'hFFFF;
            end
            1: begin
               step_word  = 16'h0001;
               scale_word = 16'h0000;
            end
            default: begin
               step_word[15]   = 1'($urandom);
               step_word[14:0] = ($urandom_range(0, 3) == 0) ?
                                 15'($urandom_range(0, 32767)) :
                                 15'($urandom_range(16, 2048));
               scale_word      = 16'($urandom);
            end
         endcase
         program_regs(step_word, scale_word);
         in_phase = 0;
         while (in_phase < 35) begin
            if ($urandom_range(0, 9) == 0) begin
               // stray command: back-to-back loads or bare ticks
               issue_command(act_type'($urandom_range(0, 1)), 16'($urandom));
               in_phase++;
            end else begin
               ticks = $urandom_range(1, 10);
               issue_command(ACT_LOAD, pick_setpoint());
               issue_ticks(ticks);
               in_phase += ticks + 1;
            end
         end
         sent += in_phase;
         phase++;
      end
      settle_outputs();
   endtask

   // Closing stretch with no idling on either side
   task automatic check_steady_tail();
      calm_tail = 1'b1;
      repeat (6) begin
         issue_command(ACT_LOAD, pick_setpoint());
         issue_ticks($urandom_range(2, 6));
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.action   = ACT_LOAD;
      req_bus.setpoint = 16'sh0000;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = CSR_RAMP_STEP;
      csr_bus.data     = 16'h0000;
      duty_now         = 0;
      duty_goal        = 0;
      step_q88         = 15'd128;
      scale_q016       = 16'd26214;
      fault_count      = 0;
      cycle_count      = 0;
      calm_tail        = 1'b0;
      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_power_on_defaults();
      check_range_extremes();
      check_stalled_step();
      check_random_ramps(130);
      check_steady_tail();

      req_bus.valid <= 1'b0;
      while (frame_due.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      if (fault_count == 0)
         $display("duty_ramp_motor_frame_builder: match");
      else
         $display("duty_ramp_motor_frame_builder: mismatch");
      $finish;
   end

endmodule
